// ===== hdl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;

  localparam int GRANS    = HEAP_BYTES / ALIGN_BYTES;
  localparam int GA_W     = $clog2(GRANS);
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
  localparam int LEN_W    = $clog2(HEAP_BYTES) + 1;
  localparam int OFF_W    = LEN_W + 2;
  localparam int PREV_W   = GA_W + 1;
  localparam int USZ_W    = LEN_W + 1;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 17;
  localparam int HB_W   = 17;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 2;
  localparam int SZ_W   = SIZE_W + 1;
  localparam int FMT_W  = (HB_W + 1 > LEN_W) ? HB_W + 1 : LEN_W;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FAIL    = 2'd1;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_HEAP_BYTES = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [ST_W-1:0]   status;
  } rsp_t;

endpackage

// ===== hdl/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  import ffa_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_addr;
  modport source (output valid, op, req_size, free_addr, input ready);
  modport sink   (input valid, op, req_size, free_addr, output ready);
endinterface

interface ffa_rsp_if;
  import ffa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_addr;
  logic [ST_W-1:0]   status;
  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

interface ffa_cfg_if;
  import ffa_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and coalescing free.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------
//  req      in   req.valid/ready    op, req_size, free_addr
//  rsp      out  rsp.valid/ready    result_addr, status
//  cfg      in   cfg.valid/ready    index (0 heap_base, 1 heap_bytes), data
//
//  One request at a time. An allocate walks the blocks from the start and
//  passes through a split state when it splits: the search issues one header
//  read per cycle on the size table and checks it the next. A free walks to
//  its block at one block per cycle, then does successor, predecessor and
//  link updates.
//  After reset and after every heap_bytes write, the first header is
//  rewritten before requests are taken; no other clearing is done.
//  A result held in the output register does not stop the next request from
//  being taken; a full output register stalls only the final handoff.
//
module first_fit_heap_allocator (
  input logic         clk,
  input logic         rst,
  ffa_req_if.sink     req,
  ffa_rsp_if.source   rsp,
  ffa_cfg_if.sink     cfg
);
  import ffa_pkg::*;

  logic [ADDR_W-1:0] heap_base;
  logic [HB_W-1:0]   heap_bytes;
  logic              fmt;
  logic              slot_free;
  logic              done;
  rsp_t              res;
  logic              rsp_valid;
  rsp_t              rsp_q;

  // configuration registers: always ready, heap_bytes writes trigger a format
  assign cfg.ready = 1'b1;
  assign fmt       = cfg.valid && cfg.index == CFG_HEAP_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= HB_W'(HEAP_BYTES);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HEAP_BASE:  heap_base  <= cfg.data;
        CFG_HEAP_BYTES: heap_bytes <= cfg.data[HB_W-1:0];
        default: ;
      endcase
    end
  end

  ffa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && req.ready),
    .op        (req.op),
    .req_size  (req.req_size),
    .free_addr (req.free_addr),
    .heap_base (heap_base),
    .heap_bytes(heap_bytes),
    .fmt       (fmt),
    .slot_free (slot_free),
    .ready     (req.ready),
    .done      (done),
    .res       (res)
  );

  // output register: load when empty or being drained
  assign slot_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (done) begin
      rsp_q <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result_addr = rsp_q.result_addr;
  assign rsp.status      = rsp_q.status;

endmodule

// ===== hdl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ffa_seq.sv =====
// ----------------------------------------------------------------------------
// ffa_seq
// Header table sequencer: format, first-fit walk, split and coalescing free.
// ----------------------------------------------------------------------------
module ffa_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  op,
  input  logic [ffa_pkg::SIZE_W-1:0] req_size,
  input  logic [ffa_pkg::ADDR_W-1:0] free_addr,
  input  logic [ffa_pkg::ADDR_W-1:0] heap_base,
  input  logic [ffa_pkg::HB_W-1:0]   heap_bytes,
  input  logic                  fmt,
  input  logic                  slot_free,
  output logic                  ready,
  output logic                  done,
  output ffa_pkg::rsp_t         res
);
  import ffa_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_CHK   = 4'd1;
  localparam logic [3:0] S_A_SPLIT = 4'd2;
  localparam logic [3:0] S_F_START = 4'd3;
  localparam logic [3:0] S_F_WALK  = 4'd4;
  localparam logic [3:0] S_F_G     = 4'd5;
  localparam logic [3:0] S_F_NX    = 4'd6;
  localparam logic [3:0] S_F_PREV  = 4'd7;
  localparam logic [3:0] S_F_P     = 4'd8;
  localparam logic [3:0] S_F_LINK  = 4'd9;
  localparam logic [3:0] S_RESP    = 4'd10;

  localparam logic [OFF_W-1:0] HDR = OFF_W'(HEADER_BYTES);

  function automatic logic [GA_W-1:0] gidx(input logic [OFF_W-1:0] x);
    return x[ALIGN_SH +: GA_W];
  endfunction

  function automatic logic fits(input logic [OFF_W-1:0] x, input logic [LEN_W-1:0] len);
    return (x + HDR) <= OFF_W'(len);
  endfunction

  // memories: used mark with size, and previous link
  logic              a_we, a_re, b_we, b_re;
  logic [GA_W-1:0]   a_waddr, a_raddr, b_waddr, b_raddr;
  logic [USZ_W-1:0]  a_wdata, a_rdata;
  logic [PREV_W-1:0] b_wdata, b_rdata;

  ffa_ram #(.WIDTH(USZ_W), .DEPTH(GRANS)) u_usz (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  ffa_ram #(.WIDTH(PREV_W), .DEPTH(GRANS)) u_prev (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  logic [3:0]        state, state_next;
  logic              fmt_pend, fmt_pend_next;
  logic [LEN_W-1:0]  heap_len, heap_len_next;
  logic [LEN_W-1:0]  off, off_next;
  logic [SZ_W-1:0]   sz, sz_next;
  logic [ADDR_W-1:0] tgt, tgt_next;
  logic [LEN_W-1:0]  gsz, gsz_next;
  logic [PREV_W-1:0] gprev, gprev_next;
  logic [GA_W-1:0]   ng, ng_next;
  logic              lnk_ok, lnk_ok_next;
  logic [GA_W-1:0]   lnk_g, lnk_g_next;
  logic              ok, ok_next;
  logic [ST_W-1:0]   status, status_next;

  logic              a_used;
  logic [LEN_W-1:0]  a_size;
  logic [OFF_W-1:0]  nxt_a, nb, nxg;
  logic [SZ_W-1:0]   rem;
  logic              fit;
  logic [FMT_W-1:0]  rb, len_c;

  assign a_used = a_rdata[LEN_W];
  assign a_size = a_rdata[LEN_W-1:0];
  assign nxt_a  = OFF_W'(off) + HDR + OFF_W'(a_size);
  assign nb     = OFF_W'(off) + HDR + OFF_W'(sz);
  assign nxg    = OFF_W'(off) + HDR + OFF_W'(gsz);
  assign rem    = SZ_W'(a_size) - sz;
  assign fit    = !a_used && (SZ_W'(a_size) >= sz);
  assign rb     = (FMT_W'(heap_bytes) + FMT_W'(ALIGN_BYTES - 1)) & ~FMT_W'(ALIGN_BYTES - 1);
  assign len_c  = (rb > FMT_W'(HEAP_BYTES)) ? FMT_W'(HEAP_BYTES) : rb;

  assign ready = (state == S_IDLE) && !fmt_pend;
  assign done  = (state == S_RESP) && slot_free;
  assign res.status      = status;
  assign res.result_addr = ok ? (heap_base + ADDR_W'(HEADER_BYTES) + ADDR_W'(off)) : '0;

  always_comb begin
    state_next    = state;
    fmt_pend_next = fmt_pend;
    heap_len_next = heap_len;
    off_next      = off;
    sz_next       = sz;
    tgt_next      = tgt;
    gsz_next      = gsz;
    gprev_next    = gprev;
    ng_next       = ng;
    lnk_ok_next   = lnk_ok;
    lnk_g_next    = lnk_g;
    ok_next       = ok;
    status_next   = status;
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;

    case (state)
      S_IDLE: begin
        if (fmt_pend) begin
          // rewrite the first header; stale entries are off the chain
          a_we    = 1'b1;
          a_wdata = {1'b0, LEN_W'(len_c - FMT_W'(HEADER_BYTES))};
          b_we    = 1'b1;
          b_wdata = {1'b1, {GA_W{1'b0}}};
          heap_len_next = (len_c <= FMT_W'(HEADER_BYTES)) ? '0 : LEN_W'(len_c);
          fmt_pend_next = 1'b0;
        end else if (start) begin
          off_next  = '0;
          ok_next   = 1'b0;
          sz_next   = (SZ_W'(req_size) + SZ_W'(ALIGN_BYTES - 1))
                      & ~SZ_W'(ALIGN_BYTES - 1);
          tgt_next  = free_addr - heap_base - ADDR_W'(HEADER_BYTES);
          if (op == OP_ALLOC) begin
            if (req_size == '0 || heap_len == '0) begin
              status_next = ST_FAIL;
              state_next  = S_RESP;
            end else begin
              a_re       = 1'b1;
              state_next = S_A_CHK;
            end
          end else begin
            if (free_addr == '0 || heap_len == '0) begin
              status_next = ST_IGNORED;
              state_next  = S_RESP;
            end else begin
              state_next = S_F_START;
            end
          end
        end
      end
      S_A_CHK: begin
        if (fit) begin
          if (rem > SZ_W'(HEADER_BYTES)) begin
            // split: new free block after the granted payload
            a_we    = 1'b1;
            a_waddr = gidx(nb);
            a_wdata = {1'b0, LEN_W'(rem - SZ_W'(HEADER_BYTES))};
            b_we    = 1'b1;
            b_waddr = gidx(nb);
            b_wdata = {1'b0, gidx(OFF_W'(off))};
            ng_next     = gidx(nb);
            lnk_ok_next = fits(nxt_a, heap_len);
            lnk_g_next  = gidx(nxt_a);
            state_next  = S_A_SPLIT;
          end else begin
            a_we    = 1'b1;
            a_waddr = gidx(OFF_W'(off));
            a_wdata = {1'b1, a_size};
            ok_next     = 1'b1;
            status_next = ST_DONE;
            state_next  = S_RESP;
          end
        end else if (fits(nxt_a, heap_len)) begin
          a_re       = 1'b1;
          a_raddr    = gidx(nxt_a);
          off_next   = LEN_W'(nxt_a);
        end else begin
          status_next = ST_FAIL;
          state_next  = S_RESP;
        end
      end
      S_A_SPLIT: begin
        a_we    = 1'b1;
        a_waddr = gidx(OFF_W'(off));
        a_wdata = {1'b1, LEN_W'(sz)};
        b_we    = lnk_ok;
        b_waddr = lnk_g;
        b_wdata = {1'b0, ng};
        ok_next     = 1'b1;
        status_next = ST_DONE;
        state_next  = S_RESP;
      end
      S_F_START: begin
        if (tgt >= ADDR_W'(heap_len)) begin
          status_next = ST_IGNORED;
          state_next  = S_RESP;
        end else if (tgt == '0) begin
          a_re = 1'b1;
          b_re = 1'b1;
          state_next = S_F_G;
        end else begin
          a_re = 1'b1;
          state_next = S_F_WALK;
        end
      end
      S_F_WALK: begin
        if (fits(nxt_a, heap_len) && ADDR_W'(nxt_a) < tgt) begin
          a_re     = 1'b1;
          a_raddr  = gidx(nxt_a);
          off_next = LEN_W'(nxt_a);
        end else if (fits(nxt_a, heap_len) && ADDR_W'(nxt_a) == tgt) begin
          a_re     = 1'b1;
          a_raddr  = gidx(nxt_a);
          b_re     = 1'b1;
          b_raddr  = gidx(nxt_a);
          off_next = LEN_W'(nxt_a);
          state_next = S_F_G;
        end else begin
          status_next = ST_IGNORED;
          state_next  = S_RESP;
        end
      end
      S_F_G: begin
        if (!a_used) begin
          status_next = ST_IGNORED;
          state_next  = S_RESP;
        end else begin
          gsz_next   = a_size;
          gprev_next = b_rdata;
          if (fits(nxt_a, heap_len)) begin
            a_re       = 1'b1;
            a_raddr    = gidx(nxt_a);
            state_next = S_F_NX;
          end else begin
            state_next = S_F_PREV;
          end
        end
      end
      S_F_NX: begin
        if (!a_used) begin
          gsz_next = LEN_W'(OFF_W'(gsz) + HDR + OFF_W'(a_size));
        end
        state_next = S_F_PREV;
      end
      S_F_PREV: begin
        if (!gprev[GA_W]) begin
          a_re       = 1'b1;
          a_raddr    = gprev[GA_W-1:0];
          state_next = S_F_P;
        end else begin
          state_next = S_F_LINK;
        end
      end
      S_F_P: begin
        if (!a_used) begin
          // absorb into the free predecessor
          gsz_next = LEN_W'(OFF_W'(a_size) + HDR + OFF_W'(gsz));
          off_next = LEN_W'({gprev[GA_W-1:0], {ALIGN_SH{1'b0}}});
        end
        state_next = S_F_LINK;
      end
      S_F_LINK: begin
        a_we    = 1'b1;
        a_waddr = gidx(OFF_W'(off));
        a_wdata = {1'b0, gsz};
        b_we    = fits(nxg, heap_len);
        b_waddr = gidx(nxg);
        b_wdata = {1'b0, gidx(OFF_W'(off))};
        status_next = ST_DONE;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fmt) begin
      fmt_pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fmt_pend <= 1'b1;
      heap_len <= '0;
    end else begin
      state    <= state_next;
      fmt_pend <= fmt_pend_next;
      heap_len <= heap_len_next;
    end
    off    <= off_next;
    sz     <= sz_next;
    tgt    <= tgt_next;
    gsz    <= gsz_next;
    gprev  <= gprev_next;
    ng     <= ng_next;
    lnk_ok <= lnk_ok_next;
    lnk_g  <= lnk_g_next;
    ok     <= ok_next;
    status <= status_next;
  end

`ifndef SYNTH
  a_no_rw_same_a: assert property (@(posedge clk) disable iff (rst)
    !(a_we && a_re && a_waddr == a_raddr))
    else $error("size table read and written at one entry");

  a_no_rw_same_b: assert property (@(posedge clk) disable iff (rst)
    !(b_we && b_re && b_waddr == b_raddr))
    else $error("link table read and written at one entry");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_DONE) |-> res.result_addr == '0)
    else $error("failed request carries an address");

  a_link_not_self: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_LINK && b_we) |-> b_waddr != gidx(OFF_W'(off)))
    else $error("block linked to itself");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Runs allocate and free requests through the first-fit heap allocator under
// several heap settings. A shadow block table predicts every response, and
// the responses are checked in order against those predictions.
// ----------------------------------------------------------------------------
module testbench;
  import ffa_pkg::*;

  localparam int unsigned LINK_NONE = 32'hFFFF_FFFF;
  localparam int          WATCHDOG  = 20000;

  typedef struct {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    rsp_t              want;
  } heap_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffa_req_if req ();
  ffa_rsp_if rsp ();
  ffa_cfg_if cfg ();

  first_fit_heap_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow block table: one entry per granule, valid only along the chain.
  bit          blk_used [GRANS];
  int unsigned blk_size [GRANS];
  int unsigned blk_link [GRANS];
  logic [ADDR_W-1:0] base_addr;
  int unsigned       heap_len;

  heap_req_t         pending_q [$];   // built requests, not yet offered
  rsp_t              response_q [$];  // responses owed by accepted requests
  logic [ADDR_W-1:0] live_q [$];      // payloads currently allocated
  logic [ADDR_W-1:0] freed_q [$];     // payloads already released

  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  heap_req_t cur;

  function automatic int unsigned round8(int unsigned v);
    return ((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic int unsigned gran(int unsigned off);
    int unsigned g;
    g = off / ALIGN_BYTES;
    return (g < GRANS) ? g : 0;
  endfunction

  function automatic bit header_fits(int unsigned off);
    return off <= heap_len && heap_len - off >= HEADER_BYTES;
  endfunction

  function automatic void format_table(int unsigned bytes);
    int unsigned len;
    len = round8(bytes);
    if (len > HEAP_BYTES) len = HEAP_BYTES;
    for (int i = 0; i < GRANS; i++) begin
      blk_used[i] = 1'b0;
      blk_size[i] = 0;
      blk_link[i] = 0;
    end
    live_q.delete();
    freed_q.delete();
    if (len <= HEADER_BYTES) begin
      heap_len = 0;
    end else begin
      heap_len    = len;
      blk_size[0] = len - HEADER_BYTES;
      blk_link[0] = LINK_NONE;
    end
  endfunction

  // First fit: walk from the start, split when the leftover exceeds a header.
  function automatic rsp_t grant_block(int unsigned want_bytes);
    rsp_t        r;
    int unsigned sz, off, g, rem, nb, ng, nx;
    r.result_addr = '0;
    r.status      = ST_FAIL;
    if (want_bytes == 0 || heap_len == 0) return r;
    sz  = round8(want_bytes);
    off = 0;
    while (header_fits(off)) begin
      g = gran(off);
      if (!blk_used[g] && blk_size[g] >= sz) begin
        rem = blk_size[g] - sz;
        if (rem > HEADER_BYTES) begin
          nb = off + HEADER_BYTES + sz;
          ng = gran(nb);
          blk_used[ng] = 1'b0;
          blk_size[ng] = rem - HEADER_BYTES;
          blk_link[ng] = g;
          nx = nb + HEADER_BYTES + blk_size[ng];
          if (header_fits(nx)) blk_link[gran(nx)] = ng;
          blk_size[g] = sz;
        end
        blk_used[g]   = 1'b1;
        r.result_addr = base_addr + ADDR_W'(HEADER_BYTES) + ADDR_W'(off);
        r.status      = ST_DONE;
        return r;
      end
      off = off + HEADER_BYTES + blk_size[g];
    end
    return r;
  endfunction

  // Release a payload and merge it with free neighbors on both sides.
  function automatic rsp_t release_block(logic [ADDR_W-1:0] addr);
    rsp_t              r;
    logic [ADDR_W-1:0] d;
    int unsigned       off, g, nx, p;
    r.result_addr = '0;
    r.status      = ST_IGNORED;
    if (addr == 0 || heap_len == 0) return r;
    d = addr - base_addr - ADDR_W'(HEADER_BYTES);
    if (d >= ADDR_W'(heap_len)) return r;
    off = 0;
    while (header_fits(off) && ADDR_W'(off) < d)
      off = off + HEADER_BYTES + blk_size[gran(off)];
    if (ADDR_W'(off) != d || !header_fits(off)) return r;
    g = gran(off);
    if (!blk_used[g]) return r;
    nx = off + HEADER_BYTES + blk_size[g];
    if (header_fits(nx) && !blk_used[gran(nx)])
      blk_size[g] += blk_size[gran(nx)] + HEADER_BYTES;
    p = blk_link[g];
    if (p != LINK_NONE && p < GRANS && !blk_used[p]) begin
      blk_size[p] += blk_size[g] + HEADER_BYTES;
      blk_used[g] = 1'b0;
      g   = p;
      off = p * ALIGN_BYTES;
    end
    nx = off + HEADER_BYTES + blk_size[g];
    if (header_fits(nx)) blk_link[gran(nx)] = g;
    blk_used[g] = 1'b0;
    r.status = ST_DONE;
    return r;
  endfunction

  // Build one request, predict its response and queue it for the driver.
  task automatic queue_alloc(int unsigned nbytes);
    heap_req_t it;
    it.op   = OP_ALLOC;
    it.size = SIZE_W'(nbytes);
    it.addr = ADDR_W'({$urandom, $urandom});
    it.want = grant_block(nbytes);
    if (it.want.status == ST_DONE) live_q.push_back(it.want.result_addr);
    pending_q.push_back(it);
  endtask

  task automatic queue_free(logic [ADDR_W-1:0] addr);
    heap_req_t it;
    it.op   = OP_FREE;
    it.size = SIZE_W'($urandom);
    it.addr = addr;
    it.want = release_block(addr);
    if (it.want.status == ST_DONE) freed_q.push_back(addr);
    pending_q.push_back(it);
  endtask

  task automatic free_live();
    int k;
    logic [ADDR_W-1:0] a;
    if (live_q.size() == 0) begin
      queue_free(ADDR_W'({$urandom, $urandom}));
      return;
    end
    k = $urandom_range(0, live_q.size() - 1);
    a = live_q[k];
    live_q.delete(k);
    queue_free(a);
  endtask

  // Random mix: mostly frees of live blocks and small allocations.
  task automatic queue_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_alloc($urandom_range(1, 256));
      end else if (pick < 48) begin
        queue_alloc($urandom_range(1, heap_len + 8));
      end else if (pick < 50) begin
        queue_alloc((pick == 48) ? 0 : $urandom_range(0, 65536));
      end else if (pick < 88) begin
        free_live();
      end else if (pick < 92 && freed_q.size() > 0) begin
        queue_free(freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else if (pick < 95) begin
        queue_free((live_q.size() > 0 ? live_q[0] : base_addr) + ADDR_W'(8));
      end else if (pick < 97) begin
        queue_free('0);
      end else begin
        queue_free(ADDR_W'({$urandom, $urandom}));
      end
    end
  endtask

  // Hold until every request has been answered and the block has settled.
  task automatic wait_drained();
    while (pending_q.size() > 0 || response_q.size() > 0 || req.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    cfg.index <= idx;
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == CFG_HEAP_BASE) base_addr = value;
    else format_table(int'(value[HB_W-1:0]));
    @(posedge clk);
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] b, int unsigned bytes, int n);
    wait_drained();
    @(posedge clk);
    write_reg(CFG_HEAP_BASE, b);
    write_reg(CFG_HEAP_BYTES, ADDR_W'(bytes));
    repeat (3) @(posedge clk);
    queue_random(n);
  endtask

  // Request driver: one valid update per edge, random gap after each request unless no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        response_q.push_back(cur.want);
        send_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          req.op        <= cur.op;
          req.req_size  <= cur.size;
          req.free_addr <= cur.addr;
          req.valid     <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random stalls, a long hold on demand, and watchdog.
  always @(posedge clk) begin
    rsp_t w;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (rsp.valid && rsp.ready) begin
        if (response_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response addr=%h status=%0d", rsp.result_addr, rsp.status);
        end else begin
          w = response_q.pop_front();
          if (rsp.result_addr !== w.result_addr || rsp.status !== w.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                       w.result_addr, w.status, rsp.result_addr, rsp.status);
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    req.valid     = 1'b0;
    req.op        = OP_ALLOC;
    req.req_size  = '0;
    req.free_addr = '0;
    rsp.ready     = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_HEAP_BASE;
    cfg.data      = '0;
    base_addr     = '0;
    format_table(65536);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed: size extremes, rounding, null, double and bad frees.
    queue_alloc(0);
    queue_alloc(65536);
    queue_alloc(1);
    queue_alloc(8);
    queue_alloc(9);
    queue_alloc(100);
    queue_free('0);
    free_live();
    queue_free(freed_q[0]);
    queue_free(live_q[0] + ADDR_W'(8));
    queue_free(ADDR_W'(48'hFFFF_FFFF_FFFF));
    queue_free(ADDR_W'(48'hAAAA_5555_AAAA));
    queue_alloc(65535);
    while (live_q.size() > 0) free_live();
    queue_alloc(65536 - HEADER_BYTES);
    queue_alloc(1);
    free_live();
    queue_alloc(32768);
    queue_alloc(32768);
    free_live();

    // Fill a small heap at a wrapping base, then empty heaps and small ones.
    run_phase(48'hFFFF_FFFF_FFFF, 256, 150);
    run_phase(ADDR_W'({$urandom, $urandom}), HEADER_BYTES, 20);
    run_phase(ADDR_W'({$urandom, $urandom}), 0, 20);
    run_phase(ADDR_W'({$urandom, $urandom}), 100, 120);
    run_phase(ADDR_W'({$urandom, $urandom}), 1001, 200);

    // Long hold on the response side while requests keep coming.
    wait_drained();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    run_phase('0, 65536, 200);
    wait_drained();
    no_idle = 1'b0;

    run_phase(ADDR_W'({$urandom, $urandom}), 4096, 250);
    run_phase(ADDR_W'({$urandom, $urandom}), 131071, 200);
    run_phase(ADDR_W'({$urandom, $urandom}), $urandom_range(0, 65536), 250);
    run_phase(ADDR_W'({$urandom, $urandom}), 2048, 250);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
